// ===== hdl/dtfp_pkg.sv =====
package dtfp_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_INT,
    PH_SKIP,
    PH_FRAC,
    PH_REST,
    PH_ENDED
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_DIGITS = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // Flags of a finished word, handed from the parser to the result stage.
  typedef struct packed {
    logic negative;
    logic seen;
    logic empty;
    logic big;
  } snap_t;

  localparam logic [7:0]  NUL_CHAR   = 8'h00;
  localparam logic [7:0]  MINUS_CHAR = 8'h2D;
  localparam logic [7:0]  DOT_CHAR   = 8'h2E;
  localparam logic [7:0]  ZERO_CHAR  = 8'h30;
  localparam logic [7:0]  NINE_CHAR  = 8'h39;
  localparam logic [63:0] TWO_POW_63 = 64'h8000_0000_0000_0000;

  // Powers of ten up to 10^18; codes past the table read as zero.
  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      5'd18:   p = 64'd1000000000000000000;
      default: p = 64'd0;
    endcase
    return p;
  endfunction

endpackage

// ===== hdl/decimal_text_to_fixed_price_unit.sv =====
// A result word passes the input, snap and output registers after its last character is accepted.
// Throughput: one character per cycle, back to back across strings, set by the
// parse step (a times-ten shift-add on the scaled integer part).
// Output is registered; while it stalls, the parser still takes characters until
// the next last-flagged one. Synchronous active-high reset clears all parse state.
module decimal_text_to_fixed_price_unit #(
  parameter int FRAC_DIGITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_byte,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] fixed_value,
  output logic [1:0]         status
);
  import dtfp_pkg::*;

  localparam int FW = $clog2(pow10(5'(FRAC_DIGITS)));

  logic          snap_valid;
  logic          snap_ready;
  snap_t         snap;
  logic [63:0]   snap_int;
  logic [FW-1:0] snap_frac;

  dtfp_parse #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .last       (last),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .snap_int   (snap_int),
    .snap_frac  (snap_frac)
  );

  dtfp_result #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_result (
    .clk         (clk),
    .rst         (rst),
    .snap_valid  (snap_valid),
    .snap_ready  (snap_ready),
    .snap        (snap),
    .snap_int    (snap_int),
    .snap_frac   (snap_frac),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fixed_value (fixed_value),
    .status      (status)
  );

endmodule

// ===== hdl/dtfp_parse.sv =====
module dtfp_parse #(
  parameter int FRAC_DIGITS = 8,
  localparam int FW = $clog2(dtfp_pkg::pow10(5'(FRAC_DIGITS)))
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            char_byte,
  input  logic                  last,
  output logic                  snap_valid,
  input  logic                  snap_ready,
  output dtfp_pkg::snap_t       snap,
  output logic [63:0]           snap_int,
  output logic [FW-1:0]         snap_frac
);
  import dtfp_pkg::*;

  localparam int CW = $clog2(FRAC_DIGITS + 1);
  localparam logic [63:0] Scale = pow10(5'(FRAC_DIGITS));

  // Input register; the digit times the scale is formed here to shorten the parse path.
  logic        in_full;
  logic [7:0]  in_char;
  logic        in_last;
  logic [63:0] in_dscale;

  // Parse state. The integer part is kept already scaled by ten to FRAC_DIGITS.
  phase_t        phase, phase_next;
  logic          negative, negative_next;
  logic          seen, seen_next;
  logic          empty, empty_next;
  logic          big, big_next;
  logic [63:0]   int_scaled, int_scaled_next;
  logic [FW-1:0] frac_accum, frac_accum_next;
  logic [CW-1:0] frac_count, frac_count_next;

  logic          consume;
  logic          is_digit;
  logic [3:0]    digit;
  logic [3:0]    digit_in;
  logic [67:0]   int_sum;
  logic          int_over;
  logic          frac_room;
  logic [4:0]    pw_idx;
  logic [FW-1:0] pw;
  logic [FW-1:0] frac_add;

  assign in_stall = in_full && in_last && !snap_ready;
  assign consume  = in_full && !in_stall;
  assign digit_in = 4'(char_byte - ZERO_CHAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (in_valid && !in_stall) begin
      in_char   <= char_byte;
      in_last   <= last;
      in_dscale <= {60'd0, digit_in} * Scale;
    end
  end

  always_comb begin
    is_digit  = (in_char >= ZERO_CHAR) && (in_char <= NINE_CHAR);
    digit     = 4'(in_char - ZERO_CHAR);
    int_sum   = ({4'd0, int_scaled} << 3) + ({4'd0, int_scaled} << 1) + {4'd0, in_dscale};
    int_over  = int_sum > {4'd0, TWO_POW_63};
    frac_room = frac_count < CW'(FRAC_DIGITS);
    pw_idx    = 5'(FRAC_DIGITS - 1) - 5'(frac_count);
    pw        = FW'(pow10(pw_idx));
    frac_add  = {{(FW-4){1'b0}}, digit} * pw;

    phase_next      = phase;
    negative_next   = negative;
    seen_next       = seen;
    empty_next      = empty;
    big_next        = big;
    int_scaled_next = int_scaled;
    frac_accum_next = frac_accum;
    frac_count_next = frac_count;

    if (in_char == NUL_CHAR && phase != PH_ENDED) begin
      if (phase == PH_START) begin
        empty_next = 1'b1;
      end
      phase_next = PH_ENDED;
    end else begin
      case (phase) inside
        PH_START: begin
          if (in_char == MINUS_CHAR) begin
            negative_next = 1'b1;
            phase_next    = PH_INT;
          end else if (is_digit) begin
            seen_next  = 1'b1;
            phase_next = PH_INT;
            if (!big) begin
              if (int_over) big_next = 1'b1;
              else int_scaled_next = int_sum[63:0];
            end
          end else begin
            phase_next = PH_REST;
          end
        end
        PH_INT: begin
          if (is_digit) begin
            seen_next = 1'b1;
            if (!big) begin
              if (int_over) big_next = 1'b1;
              else int_scaled_next = int_sum[63:0];
            end
          end else if (!seen) begin
            phase_next = PH_REST;
          end else if (in_char == DOT_CHAR) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (in_char == DOT_CHAR) phase_next = PH_FRAC;
        end
        PH_FRAC: begin
          if (is_digit) begin
            if (frac_room) begin
              frac_accum_next = frac_accum + frac_add;
              frac_count_next = frac_count + CW'(1);
            end
          end else begin
            phase_next = PH_REST;
          end
        end
        PH_REST, PH_ENDED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (consume && in_last)) begin
      phase      <= PH_START;
      negative   <= 1'b0;
      seen       <= 1'b0;
      empty      <= 1'b0;
      big        <= 1'b0;
      int_scaled <= 64'd0;
      frac_accum <= '0;
      frac_count <= '0;
    end else if (consume) begin
      phase      <= phase_next;
      negative   <= negative_next;
      seen       <= seen_next;
      empty      <= empty_next;
      big        <= big_next;
      int_scaled <= int_scaled_next;
      frac_accum <= frac_accum_next;
      frac_count <= frac_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_ready) begin
      snap_valid <= consume && in_last;
    end
    if (consume && in_last) begin
      snap      <= '{negative: negative_next, seen: seen_next, empty: empty_next,
                     big: big_next};
      snap_int  <= int_scaled_next;
      snap_frac <= frac_accum_next;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (consume && in_last) |=> (phase == PH_START && frac_count == '0 && !seen))
    else $error("parser did not return to the start after the last character");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    frac_count <= CW'(FRAC_DIGITS))
    else $error("fraction digit count ran past FRAC_DIGITS");

  a_big_has_digits: assert property (@(posedge clk) disable iff (rst)
    snap_valid |-> (!snap.big || snap.seen) && !(snap.empty && snap.seen))
    else $error("inconsistent flags in a finished word");

endmodule

// ===== hdl/dtfp_result.sv =====
module dtfp_result #(
  parameter int FRAC_DIGITS = 8,
  localparam int FW = $clog2(dtfp_pkg::pow10(5'(FRAC_DIGITS)))
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  snap_valid,
  output logic                  snap_ready,
  input  dtfp_pkg::snap_t       snap,
  input  logic [63:0]           snap_int,
  input  logic [FW-1:0]         snap_frac,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [63:0]    fixed_value,
  output logic [1:0]            status
);
  import dtfp_pkg::*;

  logic [63:0] frac_ext;
  logic [64:0] total;
  logic [63:0] neg_mag;
  logic [64:0] limit;
  logic        over;
  status_t     st;
  logic [63:0] value;

  status_t     result_status;
  logic [63:0] result_value;

  assign snap_ready = !out_valid || !out_stall;

  always_comb begin
    frac_ext = 64'(snap_frac);
    total    = {1'b0, snap_int} + {1'b0, frac_ext};
    // Two's complement of the sum, formed in parallel with it.
    neg_mag  = ~snap_int + ~frac_ext + 64'd2;
    limit    = snap.negative ? {1'b0, TWO_POW_63} : {1'b0, TWO_POW_63 - 64'd1};
    over     = total > limit;
    if (snap.empty) begin
      st = ST_EMPTY;
    end else if (!snap.seen) begin
      st = ST_NO_DIGITS;
    end else if (snap.big || over) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end
    if (st != ST_OK) begin
      value = 64'd0;
    end else if (snap.negative) begin
      value = neg_mag;
    end else begin
      value = total[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (snap_ready) begin
      out_valid <= snap_valid;
    end
    if (snap_valid && snap_ready) begin
      result_status <= st;
      result_value  <= value;
    end
  end

  assign fixed_value = $signed(result_value);
  assign status      = result_status;

  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_status != ST_OK) |-> result_value == 64'd0)
    else $error("nonzero value delivered with an error status");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (snap_valid && snap_ready && snap.empty) |=> (out_valid && result_status == ST_EMPTY))
    else $error("empty text did not report the empty status");

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtfp_pkg::*;

  localparam int FRAC_DIGITS = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] c;
    logic       l;
  } char_item_t;

  typedef struct {
    logic signed [63:0] value;
    status_t            st;
  } price_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_byte = 8'h00;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [63:0] fixed_value;
  logic [1:0]         status;

  decimal_text_to_fixed_price_unit #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .fixed_value(fixed_value),
    .status     (status)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  char_item_t pending_chars[$];
  price_t     expected_prices[$];
  char_item_t next_char;
  int         total_chars = 1;
  int         n_chars_in = 0;
  int         n_mismatches = 0;
  int         hold_left = 0;
  bit         pressure_done = 1'b0;
  int         quiet_cycles = 0;

  // Parser state of the prediction, cleared after every result word.
  phase_t      prs_phase = PH_START;
  logic        prs_neg = 1'b0;
  logic        prs_seen = 1'b0;
  logic [63:0] prs_int = '0;
  logic [63:0] prs_frac = '0;
  int          prs_nfrac = 0;
  status_t     prs_err = ST_OK;

  function automatic logic [63:0] ten_to(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  task automatic take_int_digit(input logic [63:0] d);
    if (prs_err != ST_RANGE) begin
      if (prs_int > (TWO_POW_63 - d) / 10) prs_err = ST_RANGE;
      else prs_int = prs_int * 10 + d;
    end
  endtask

  task automatic parse_price_char(input logic [7:0] c, input logic lst);
    logic [63:0] d;
    logic [63:0] scale;
    logic [63:0] fr;
    logic [63:0] lim;
    logic [63:0] m;
    logic        dig;
    price_t      res;
    d = {56'd0, c} - {56'd0, ZERO_CHAR};
    dig = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
    if (c == NUL_CHAR && prs_phase != PH_ENDED) begin
      if (prs_phase == PH_START) prs_err = ST_EMPTY;
      prs_phase = PH_ENDED;
    end else begin
      case (prs_phase)
        PH_START: begin
          if (c == MINUS_CHAR) begin
            prs_neg = 1'b1;
            prs_phase = PH_INT;
          end else if (dig) begin
            prs_seen = 1'b1;
            take_int_digit(d);
            prs_phase = PH_INT;
          end else begin
            prs_phase = PH_REST;
          end
        end
        PH_INT: begin
          if (dig) begin
            prs_seen = 1'b1;
            take_int_digit(d);
          end else if (!prs_seen) begin
            prs_phase = PH_REST;
          end else if (c == DOT_CHAR) begin
            prs_phase = PH_FRAC;
          end else begin
            prs_phase = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (c == DOT_CHAR) prs_phase = PH_FRAC;
        end
        PH_FRAC: begin
          if (dig) begin
            if (prs_nfrac < FRAC_DIGITS) begin
              prs_frac = prs_frac * 10 + d;
              prs_nfrac++;
            end
          end else begin
            prs_phase = PH_REST;
          end
        end
        default: ;
      endcase
    end
    if (lst) begin
      res.value = '0;
      if (prs_err == ST_EMPTY) begin
        res.st = ST_EMPTY;
      end else if (!prs_seen) begin
        res.st = ST_NO_DIGITS;
      end else if (prs_err == ST_RANGE) begin
        res.st = ST_RANGE;
      end else begin
        scale = ten_to(FRAC_DIGITS);
        fr = prs_frac * ten_to(FRAC_DIGITS - prs_nfrac);
        lim = prs_neg ? TWO_POW_63 : TWO_POW_63 - 1;
        if (fr > lim || prs_int > (lim - fr) / scale) begin
          res.st = ST_RANGE;
        end else begin
          m = prs_int * scale + fr;
          res.value = prs_neg ? -m : m;
          res.st = ST_OK;
        end
      end
      expected_prices.push_back(res);
      prs_phase = PH_START;
      prs_neg = 1'b0;
      prs_seen = 1'b0;
      prs_int = '0;
      prs_frac = '0;
      prs_nfrac = 0;
      prs_err = ST_OK;
    end
  endtask

  task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                 input logic signed [63:0] want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    n_mismatches++;
  endtask

  // Idle rates move through three phases of the run, keyed on characters accepted.
  function automatic int send_idle_pct();
    if (n_chars_in < total_chars / 3) return 9;
    if (n_chars_in < 2 * total_chars / 3) return 67;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (n_chars_in < total_chars / 3) return 67;
    if (n_chars_in < 2 * total_chars / 3) return 9;
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      char_byte <= 8'h00;
      last <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_price_char(char_byte, last);
        n_chars_in <= n_chars_in + 1;
      end
      if (!in_valid || !in_stall) begin
        if (pending_chars.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_char = pending_chars.pop_front();
          in_valid <= 1'b1;
          char_byte <= next_char.c;
          last <= next_char.l;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // A long hold-off late in the run, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!pressure_done && n_chars_in >= total_chars * 5 / 6) begin
        hold_left <= HOLD_CYCLES;
        pressure_done <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    price_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_prices.size() == 0) begin
          report_mismatch("unexpected word", fixed_value, 64'sd0);
        end else begin
          want = expected_prices.pop_front();
          if (fixed_value !== want.value)
            report_mismatch("fixed_value", fixed_value, want.value);
          if (status !== want.st)
            report_mismatch("status", {62'd0, status}, {62'd0, want.st});
        end
      end
      out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_char(input logic [7:0] c);
    char_item_t it;
    it.c = c;
    it.l = 1'b0;
    pending_chars.push_back(it);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic end_word();
    char_item_t it;
    it = pending_chars.pop_back();
    it.l = 1'b1;
    pending_chars.push_back(it);
  endtask

  task automatic push_line(input string s);
    push_text(s);
    end_word();
  endtask

  function automatic logic [7:0] rand_digit();
    return ZERO_CHAR + 8'($urandom_range(9));
  endfunction

  // Any byte that is neither a digit, a dot nor a zero byte.
  function automatic logic [7:0] rand_junk();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= ZERO_CHAR && c <= NINE_CHAR) || c == DOT_CHAR);
    return c;
  endfunction

  task automatic push_random_word();
    int r;
    int n;
    r = $urandom_range(99);
    if (r < 82) begin
      if ($urandom_range(2) == 0) push_char(MINUS_CHAR);
      r = $urandom_range(99);
      if (r < 8) begin
        // Near the edge of the 64-bit range once scaled.
        push_text("922337203");
        push_char(ZERO_CHAR + 8'($urandom_range(6, 8)));
        push_char(rand_digit());
        push_char(DOT_CHAR);
        push_text("547758");
        push_char(rand_digit());
        push_char(rand_digit());
      end else begin
        if (r < 70) n = $urandom_range(1, 4);
        else if (r < 88) n = $urandom_range(5, 12);
        else n = $urandom_range(13, 21);
        for (int i = 0; i < n; i++) push_char(rand_digit());
        if ($urandom_range(9) == 0) begin
          n = $urandom_range(1, 3);
          for (int i = 0; i < n; i++) push_char(rand_junk());
        end
        if ($urandom_range(99) < 85) begin
          push_char(DOT_CHAR);
          n = ($urandom_range(9) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 8);
          for (int i = 0; i < n; i++) push_char(rand_digit());
        end
      end
      r = $urandom_range(99);
      if (r >= 40) begin
        push_char((r < 70) ? NUL_CHAR : rand_junk());
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)));
      end
    end else begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) push_char(8'($urandom_range(255)));
    end
    end_word();
  endtask

  initial begin
    push_char(NUL_CHAR);
    end_word();
    push_line("0");
    push_line("-0");
    push_line("-0.5");
    push_line("123.45678901234");
    push_line("92233720368.54775807");
    push_line("-92233720368.54775808");
    push_line("92233720368.54775808");
    push_line("9223372036854775808");
    push_line("99999999999999999999");
    push_line("-");
    push_line(".5");
    push_line("+5");
    push_line(" 5");
    push_line("-abc");
    push_line("12abc.34");
    push_line("12.34x99");
    push_line("7.");
    push_text("12");
    push_char(NUL_CHAR);
    push_text("9.9");
    push_char(NUL_CHAR);
    end_word();
    push_text("-3.25");
    push_char(8'hFF);
    push_char(8'h80);
    end_word();
    push_char(8'hFF);
    push_char(8'h35);
    end_word();
    while (pending_chars.size() < 1400) push_random_word();
    total_chars = pending_chars.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() > 0 || in_valid) @(posedge clk);
    while (expected_prices.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (n_mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/dtfp_pkg.sv
hdl/dtfp_parse.sv
hdl/dtfp_result.sv
hdl/decimal_text_to_fixed_price_unit.sv
bench/tb_top.sv
